// File: rtl/core/pgalloc_pkg.sv
`timescale 1ns / 1ps

package pgalloc_pkg;

  // Request codes on the func field.
  localparam logic [2:0] FUNC_ALLOC = 3'd0;
  localparam logic [2:0] FUNC_FREE  = 3'd1;
  localparam logic [2:0] FUNC_INC   = 3'd2;
  localparam logic [2:0] FUNC_DEC   = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_LIMIT = 2'd3;

  // Entries in the queue between classifier and executor.
  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] page_address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [27:0] granted_address;
    logic [7:0]  reference_count;
    logic [16:0] free_page_total;
  } out_word_t;

  // Classified operation; address checks are already folded into OP_BAD.
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INC,
    OP_DEC,
    OP_READ,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] page_address;
  } cmd_t;

endpackage

// File: rtl/core/pgalloc_front.sv
`timescale 1ns / 1ps

module pgalloc_front
  import pgalloc_pkg::*;
#(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [28:0] cfg_wdata,
  input  logic        push,
  input  in_word_t    in_word,
  input  logic        q_full,
  input  logic        clearing,
  output logic        full,
  output logic        q_push,
  output cmd_t        q_data
);

  localparam int PN_W = 32 - PAGE_SHIFT;

  logic [28:0]     lowest_r;
  logic [PN_W-1:0] page_num;
  logic            in_range;
  logic            above_low;
  logic            aligned;
  logic            addr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= '0;
    end else if (cfg_we) begin
      lowest_r <= cfg_wdata;
    end
  end

  assign full   = q_full | clearing;
  assign q_push = push & ~full;

  assign page_num  = in_word.page_address[31:PAGE_SHIFT];
  assign in_range  = 64'(page_num) < 64'(PAGE_COUNT);
  assign above_low = in_word.page_address >= {3'b000, lowest_r};
  assign aligned   = in_word.page_address[PAGE_SHIFT-1:0] == '0;
  assign addr_ok   = in_range & above_low;

  always_comb begin
    q_data.page_address = in_word.page_address;
    case (in_word.func)
      FUNC_ALLOC: q_data.op = OP_ALLOC;
      FUNC_FREE:  q_data.op = (addr_ok && aligned) ? OP_FREE : OP_BAD;
      FUNC_INC:   q_data.op = addr_ok ? OP_INC : OP_BAD;
      FUNC_DEC:   q_data.op = addr_ok ? OP_DEC : OP_BAD;
      FUNC_READ:  q_data.op = addr_ok ? OP_READ : OP_BAD;
      default:    q_data.op = OP_BAD;
    endcase
  end

endmodule

// File: rtl/core/pgalloc_cmdq.sv
`timescale 1ns / 1ps

module pgalloc_cmdq
  import pgalloc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  cmd_t q_data,
  input  logic q_pop,
  output logic q_full,
  output logic q_empty,
  output cmd_t q_head
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic [PTR_W:0]   cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_full  = cnt_r == (PTR_W + 1)'(CMDQ_DEPTH);
  assign q_empty = cnt_r == '0;
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (q_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_data;
    end
  end

endmodule

// File: rtl/core/pgalloc_back.sv
`timescale 1ns / 1ps

module pgalloc_back
  import pgalloc_pkg::*;
#(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      clearing,
  input  logic      pop,
  output logic      empty,
  output out_word_t out_word
);

  localparam int PG_W    = $clog2(PAGE_COUNT);
  localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [PG_W-1:0]       stack_mem [PAGE_COUNT];
  logic [COUNT_BITS-1:0] cnt_mem   [PAGE_COUNT];

  cmd_t                  cmd_r;
  logic [DEPTH_W-1:0]    depth_r;
  logic [DEPTH_W-1:0]    depth_nxt;
  logic [DEPTH_W-1:0]    depth_dec;
  logic [PG_W-1:0]       clr_idx_r;
  logic [PG_W-1:0]       rd_stk_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;
  out_word_t             out_r;
  out_word_t             res;
  logic                  out_valid_r;

  logic                  start;
  logic                  exec;
  logic [PG_W-1:0]       head_idx;
  logic [PG_W-1:0]       cmd_idx;
  logic                  stk_we;
  logic                  cnt_upd;
  logic [COUNT_BITS-1:0] cnt_val;
  logic                  cnt_we;
  logic [PG_W-1:0]       cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  assign clearing = state_r == ST_CLEAR;
  assign exec     = state_r == ST_EXEC;
  assign empty    = ~out_valid_r;
  assign out_word = out_r;

  // The output slot is free at the write-back edge if it is empty now or
  // being taken in this cycle.
  assign start = (state_r == ST_IDLE) && !q_empty && (!out_valid_r || pop);
  assign q_pop = start;

  assign head_idx  = PG_W'(q_head.page_address[31:PAGE_SHIFT]);
  assign cmd_idx   = PG_W'(cmd_r.page_address[31:PAGE_SHIFT]);
  assign depth_dec = depth_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_idx_r == PG_W'(PAGE_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Executes the command held in cmd_r with the stack and count entries registered when it left the queue.
  always_comb begin
    res.status          = STATUS_OK;
    res.granted_address = '0;
    res.reference_count = '0;
    depth_nxt           = depth_r;
    stk_we              = 1'b0;
    cnt_upd             = 1'b0;
    cnt_val             = rd_cnt_r;
    case (cmd_r.op)
      OP_ALLOC: begin
        if (depth_r == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          depth_nxt           = depth_dec;
          res.granted_address = 28'({rd_stk_r, {PAGE_SHIFT{1'b0}}});
        end
      end
      OP_FREE: begin
        if (depth_r == DEPTH_W'(PAGE_COUNT)) begin
          res.status = STATUS_LIMIT;
        end else begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
      end
      OP_INC: begin
        if (rd_cnt_r == '1) begin
          res.status = STATUS_LIMIT;
        end else begin
          cnt_val = rd_cnt_r + 1'b1;
          cnt_upd = 1'b1;
        end
        res.reference_count = 8'(cnt_val);
      end
      OP_DEC: begin
        if (rd_cnt_r == '0) begin
          res.status = STATUS_LIMIT;
        end else begin
          cnt_val = rd_cnt_r - 1'b1;
          cnt_upd = 1'b1;
        end
        res.reference_count = 8'(cnt_val);
      end
      OP_READ: begin
        res.reference_count = 8'(rd_cnt_r);
      end
      default: begin
        res.status = STATUS_BAD;
      end
    endcase
    res.free_page_total = 17'(depth_nxt);
  end

  // The count memory is written by the clearing sweep or by write-back.
  always_comb begin
    if (clearing) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = exec & cnt_upd;
      cnt_waddr = cmd_idx;
      cnt_wdata = cnt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (exec) begin
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= q_head;
    end
    if (exec) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_stk_r <= stack_mem[depth_dec[PG_W-1:0]];
    end
    if (exec && stk_we) begin
      stack_mem[depth_r[PG_W-1:0]] <= cmd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_cnt_r <= cnt_mem[head_idx];
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

endmodule

// File: rtl/core/page_allocator_with_refcounts.sv
`timescale 1ns / 1ps

// Channel   Ports                       Direction  Word
// request   push, full, in_word         in         in_word_t (func, page_address)
// result    pop, empty, out_word        out        out_word_t (status, address, count, total)
// config    cfg_we, cfg_wdata           in         lowest_page_address, 29 bits
//
// In the executor each request first reads the stack or count memory entry, then
// writes it back and loads the result register; only then is the next one taken.
// After reset all PAGE_COUNT entries of the count memory (65536 by default) are
// swept to zero, one entry per cycle; full stays high during the sweep.
// A two-word command queue sits between classifier and executor, so up to two
// more requests are accepted while a result waits for pop; then full rises.

module page_allocator_with_refcounts
  import pgalloc_pkg::*;
#(
  parameter int PAGE_COUNT = 65536,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [28:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic clearing;
  cmd_t q_data;
  cmd_t q_head;

  pgalloc_front #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .in_word   (in_word),
    .q_full    (q_full),
    .clearing  (clearing),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  pgalloc_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  pgalloc_back #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

endmodule
